// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error("%m: lbl");
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) else $error("%m: lbl");
`endif

// File: hdl/nicr_pkg.sv
// Package for the Newton implicit curve root finder
package nicr_pkg;
  localparam int FRAC_BITS = 28;
  localparam int WORD_WIDTH = 32;
  localparam int DIV_STEPS = 128;

  typedef enum logic [1:0] {
    ST_CONV = 2'd0,
    ST_ESC = 2'd1,
    ST_LIMIT = 2'd2,
    ST_ZERO = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_XX, OP_X4, OP_X2F, OP_YY, OP_X3, OP_D1, OP_D2, OP_X8, OP_DIV
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_MUL, S_MULW, S_DIV, S_DIVW, S_UPD, S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    op_e op;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic d_zero;
    logic conv;
    logic esc;
  } stat_t;

  localparam logic signed [63:0] QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] QMIN = 64'sh8000_0000_0000_0000;

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                  logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(QMAX)) return QMAX;
    if (s < 65'(QMIN)) return QMIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                  logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(QMAX)) return QMAX;
    if (s < 65'(QMIN)) return QMIN;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] smag(logic [63:0] m, logic neg);
    logic [63:0] r;
    r = m[63] ? 64'(QMAX) : m;
    return neg ? -$signed(r) : $signed(r);
  endfunction
endpackage

// File: hdl/nicr_datapath.sv
// Datapath: iterate registers, serial multiplier and serial divider
`include "assert_macros.svh"
module nicr_datapath (
  input  logic clk_i,
  input  logic rst_ni,
  input  nicr_pkg::cmd_t cmd_i,
  input  logic along_y_i,
  input  logic signed [30:0] x_i,
  input  logic signed [30:0] y_i,
  input  logic [15:0] tol_i,
  output nicr_pkg::stat_t stat_o,
  output logic signed [63:0] t_o
);
  import nicr_pkg::*;

  logic signed [63:0] x_q, x_d, y_q, y_d, t_q, t_d;
  logic signed [63:0] xx_q, f_q, d_q, acc_q;
  logic signed [63:0] ma_q, mb_q, res_q, res_d;
  logic [127:0] prod_q, prod_d;
  logic [63:0] mpc_q, mpc_d;
  logic [6:0] cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d, ud_q, q_q, q_d;
  logic [127:0] num_q, num_d;
  logic ovf_q, ovf_d, neg_q, busy_q, busy_d, isdiv_q;
  op_e op_q;
  logic signed [63:0] four, eight, two;
  logic signed [63:0] nt, xs, ys;
  logic [63:0] un;
  logic [64:0] r2;
  logic top, ge;

  assign four = 64'sd4 <<< FRAC_BITS;
  assign eight = 64'sd8 <<< FRAC_BITS;
  assign two = 64'sd2 <<< FRAC_BITS;
  assign xs = along_y_i ? x_q : t_q;
  assign ys = along_y_i ? t_q : y_q;

  always_comb begin
    r2 = {rem_q, num_q[127]};
    top = rem_q[63];
    ge = top || (r2[63:0] >= ud_q);
    un = mag(f_q);
  end

  assign nt = sat_sub(t_q, res_q);

  always_comb begin
    x_d = x_q; y_d = y_q; t_d = t_q; res_d = res_q;
    prod_d = prod_q; mpc_d = mpc_q; cnt_d = cnt_q; busy_d = busy_q;
    rem_d = rem_q; num_d = num_q; q_d = q_q; ovf_d = ovf_q;
    if (cmd_i.load) begin
      x_d = 64'(x_i); y_d = 64'(y_i);
      t_d = along_y_i ? 64'(y_i) : 64'(x_i);
    end
    if (cmd_i.update) t_d = nt;
    if (cmd_i.start) begin
      busy_d = 1'b1; cnt_d = '0; prod_d = '0; rem_d = '0; q_d = '0; ovf_d = 1'b0;
      num_d = {un, 64'd0} >> (64 - FRAC_BITS);
    end else if (busy_q) begin
      cnt_d = cnt_q + 7'd1;
      if (isdiv_q) begin
        num_d = {num_q[126:0], 1'b0};
        if (ge) begin
          rem_d = r2[63:0] - ud_q;
          if (cnt_q <= 7'd64) ovf_d = 1'b1;
          else q_d = q_q | (64'd1 << (7'd127 - cnt_q));
        end else rem_d = r2[63:0];
        if (cnt_q == 7'(DIV_STEPS - 1)) busy_d = 1'b0;
      end else begin
        if (mpc_q[0]) prod_d = prod_q + {mag(ma_q), 64'd0};
        prod_d = {1'b0, prod_d[127:1]};
        if (cnt_q == 7'd63) busy_d = 1'b0;
      end
    end
    if (busy_q && !busy_d) begin
      if (isdiv_q) res_d = smag(ovf_d ? 64'(QMAX) : q_d, neg_q);
      else res_d = smag(mres_next(prod_d), ma_q[63] ^ mb_q[63]);
    end
    mpc_d = (cmd_i.start) ? mag(mb_sel()) : (busy_q ? {1'b0, mpc_q[63:1]} : mpc_q);
  end

  function automatic logic [63:0] mres_next(logic [127:0] p);
    return (p[127:64+FRAC_BITS] != '0) ? 64'(QMAX) : p[FRAC_BITS +: 64];
  endfunction

  function automatic logic signed [63:0] ma_sel();
    case (cmd_i.op)
      OP_XX: return xs;
      OP_X4: return xx_q;
      OP_X2F: return xx_q;
      OP_YY: return ys;
      OP_X3: return xs;
      OP_D1: return acc_q;
      OP_D2: return res_q;
      OP_X8: return along_y_i ? ys : xs;
      default: return f_q;
    endcase
  endfunction

  function automatic logic signed [63:0] mb_sel();
    case (cmd_i.op)
      OP_XX: return xs;
      OP_X4: return xx_q;
      OP_X2F: return four;
      OP_YY: return ys;
      OP_X3: return xs;
      OP_D1: return xs;
      OP_D2: return four;
      OP_X8: return along_y_i ? two : eight;
      default: return d_q;
    endcase
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; t_q <= t_d; res_q <= res_d;
    prod_q <= prod_d; mpc_q <= mpc_d; cnt_q <= cnt_d;
    rem_q <= rem_d; num_q <= num_d; q_q <= q_d; ovf_q <= ovf_d;
    if (cmd_i.start) begin
      op_q <= cmd_i.op;
      isdiv_q <= (cmd_i.op == OP_DIV);
      ma_q <= ma_sel();
      mb_q <= mb_sel();
      ud_q <= mag(d_q);
      neg_q <= f_q[63] ^ d_q[63];
    end
    if (busy_q && !busy_d) begin
      case (op_q)
        OP_XX: xx_q <= res_d;
        OP_X4: f_q <= res_d;
        OP_X2F: f_q <= sat_sub(f_q, res_d);
        OP_YY: f_q <= sat_add(f_q, res_d);
        OP_X3: acc_q <= res_d;
        OP_D1: acc_q <= res_d;
        OP_D2: d_q <= res_d;
        OP_X8: d_q <= along_y_i ? res_d : sat_sub(d_q, res_d);
        default: ;
      endcase
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.d_zero = (d_q == '0);
  assign stat_o.conv = mag(sat_sub(nt, t_q)) <= 64'(tol_i);
  assign stat_o.esc = mag(nt) > 64'(two);
  assign t_o = t_q;

  `ASSERT_NEXT(a_start_busy, cmd_i.start, busy_q)
  `ASSERT_IMPL(a_no_start_busy, !(cmd_i.start && busy_q))
  `ASSERT_IMPL(a_no_upd_busy, !(cmd_i.update && busy_q))
endmodule

// File: hdl/nicr_ctrl.sv
// Controller: sequences the Newton steps and the handshake
`include "assert_macros.svh"
module nicr_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  logic along_y_i,
  input  logic [5:0] max_iter_i,
  input  nicr_pkg::stat_t stat_i,
  output nicr_pkg::cmd_t cmd_o,
  output logic [1:0] status_o
);
  import nicr_pkg::*;

  state_e state_q, state_d;
  op_e op_q, op_d;
  logic [5:0] k_q, k_d;
  status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; op_q <= OP_XX; k_q <= '0; st_q <= ST_LIMIT;
    end else begin
      state_q <= state_d; op_q <= op_d; k_q <= k_d; st_q <= st_d;
    end
  end

  always_comb begin
    state_d = state_q; op_d = op_q; k_d = k_q; st_d = st_q;
    cmd_o = '{load: 1'b0, start: 1'b0, op: op_q, update: 1'b0};
    in_ready_o = 1'b0; out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1; k_d = '0; st_d = ST_LIMIT;
          op_d = OP_XX;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (k_q >= max_iter_i) state_d = S_OUT;
        else state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.start = 1'b1; state_d = S_MULW;
      end
      S_MULW: begin
        if (!stat_i.busy) begin
          state_d = S_MUL;
          case (op_q)
            OP_XX: op_d = OP_X4;
            OP_X4: op_d = OP_X2F;
            OP_X2F: op_d = OP_YY;
            OP_YY: op_d = along_y_i ? OP_X8 : OP_X3;
            OP_X3: op_d = OP_D1;
            OP_D1: op_d = OP_D2;
            OP_D2: op_d = OP_X8;
            default: state_d = S_DIV;
          endcase
        end
      end
      S_DIV: begin
        if (stat_i.d_zero) begin
          st_d = ST_ZERO; state_d = S_OUT;
        end else begin
          cmd_o.op = OP_DIV; cmd_o.start = 1'b1; op_d = OP_DIV; state_d = S_DIVW;
        end
      end
      S_DIVW: if (!stat_i.busy) state_d = S_UPD;
      S_UPD: begin
        cmd_o.update = 1'b1; k_d = k_q + 6'd1;
        op_d = OP_XX;
        if (stat_i.conv || stat_i.esc) begin
          st_d = stat_i.esc ? ST_ESC : ST_CONV; state_d = S_OUT;
        end else state_d = S_CHECK;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign status_o = st_q;

  `ASSERT_IMPL(a_excl, !(in_ready_o && out_valid_o))
  `ASSERT_NEXT(a_load_check, in_valid_i && in_ready_o, state_q == S_CHECK)
  `ASSERT_IMPL(a_k_bound, (state_q != S_MUL) || (k_q < max_iter_i))
endmodule

// File: hdl/newton_implicit_curve_root.sv
// Newton implicit curve root finder, top level
// Usage:
// Input channel s_axis: tdata = {y_coord, x_coord} (31 bits each, signed
// Q3.28), tuser = command (0 solve along x, 1 along y). One item is worked
// at a time; s_axis_tready is high only while the block is idle.
// Output channel m_axis: tdata = root (32 bits), tuser = status.
// Each item takes k Newton steps, where k is at most max_iterations, and
// each step runs N_mul multiplications, N_mul being 5 along y and 8 along
// x, on the serial shift-add multiplier and then one division on the
// restoring divider, unless the divisor is zero.
// The result is held on m_axis until m_axis_tready; no new item is taken
// meanwhile. Reset clears the controller and sets max_iterations to 10
// and tolerance to 0. Configuration is written through cfg_we_i,
// cfg_index_i and cfg_data_i while idle.
module newton_implicit_curve_root (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [63:0] s_axis_tdata, // x_coord[30:0], y_coord[61:31], zeros
  input  logic s_axis_tuser,        // command
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [31:0] m_axis_tdata, // root
  output logic [1:0] m_axis_tuser,  // status
  input  logic cfg_we_i,
  input  logic cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import nicr_pkg::*;

  logic [5:0] max_iter_q;
  logic [15:0] tol_q;
  logic along_y_q;
  cmd_t cmd;
  stat_t stat;
  logic signed [63:0] t;
  logic signed [63:0] wmax, wmin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= 6'd10; tol_q <= '0; along_y_q <= 1'b0;
    end else begin
      if (cfg_we_i && !cfg_index_i) max_iter_q <= cfg_data_i[5:0];
      if (cfg_we_i && cfg_index_i) tol_q <= cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) along_y_q <= s_axis_tuser;
    end
  end

  nicr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .along_y_i(s_axis_tready ? s_axis_tuser : along_y_q),
    .max_iter_i(max_iter_q), .stat_i(stat), .cmd_o(cmd), .status_o(m_axis_tuser)
  );

  nicr_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .along_y_i(s_axis_tready ? s_axis_tuser : along_y_q),
    .x_i(s_axis_tdata[30:0]), .y_i(s_axis_tdata[61:31]),
    .tol_i(tol_q), .stat_o(stat), .t_o(t)
  );

  assign wmax = (64'sd1 <<< (WORD_WIDTH - 1)) - 64'sd1;
  assign wmin = -wmax - 64'sd1;
  assign m_axis_tdata = (t > wmax) ? wmax[31:0] : ((t < wmin) ? wmin[31:0] : t[31:0]);
endmodule
